FILE: hw/rtl/htdec_pkg.sv
// Shared types and constants of the Huffman table load and decode unit.
package htdec_pkg;

  localparam logic [7:0]  CH_ONE             = 8'h31;   // ASCII '1'
  localparam logic [7:0]  CH_NEWLINE         = 8'h0a;   // ASCII newline
  localparam logic [7:0]  EMPTY_SYMBOL       = 8'h00;
  localparam logic [15:0] TABLE_LENGTH_RESET = 16'd218;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_LVL_W = OUTQ_PTR_W + 1;

  typedef struct packed {
    logic [7:0] sym;
    logic       ovf;
    logic       last;
  } result_t;

  // Up to two results handed from the walk stage to the result queue per cycle.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r1;
    result_t    r0;
  } push_t;

endpackage

FILE: hw/rtl/huffman_table_load_and_decode_unit.sv
// Top level of the Huffman table load and decode unit.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------------
//   s_axis   | in        | s_axis_tvalid/tready      | tdata=stream_byte, tlast=final_byte
//   m_axis   | out       | m_axis_tvalid/tready      | tdata=symbol, tuser=index_overflow,
//            |           |                           | tlast=last_of_run
//   cfg      | in        | cfg_valid/cfg_ready       | cfg_data=table_length
//
// One input byte a cycle is taken while s_axis_tready is high; the loop that sets this is the
// code tree RAM read feeding the next walk index. Results pass through the s1 stage registers
// and the result queue. A byte with two results takes two queue entries, so input may stall.
// After reset the tree RAM is cleared one entry a cycle, with s_axis_tready low throughout.
// cfg writes are taken at any time (cfg_ready is always high).
module huffman_table_load_and_decode_unit #(
  parameter int TREE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] symbol
  output logic        m_axis_tuser,   // [0] index_overflow
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // table_length
);

  localparam int IDX_W = $clog2(TREE_ENTRIES);

  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  logic [7:0]                       ram_wdata;
  logic                             ram_re;
  logic [IDX_W-1:0]                 ram_raddr;
  logic [7:0]                       ram_rdata;
  htdec_pkg::push_t                 push;
  htdec_pkg::result_t               out_res;
  logic [htdec_pkg::OUTQ_LVL_W-1:0] outq_level;

  // Register writes land in table_length with no back pressure.
  assign cfg_ready = 1'b1;

  // Code tree store: one symbol byte per heap index.
  htdec_ram #(
    .WIDTH (8),
    .DEPTH (TREE_ENTRIES)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Table load, clearing pass and code walk; stages results for the queue.
  htdec_ctrl #(
    .TREE_ENTRIES (TREE_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_final   (s_axis_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .outq_level (outq_level),
    .push       (push),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Result queue decouples the walk from output stalls.
  htdec_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .level     (outq_level)
  );

  assign m_axis_tdata = out_res.sym;
  assign m_axis_tuser = out_res.ovf;
  assign m_axis_tlast = out_res.last;

endmodule

FILE: hw/rtl/htdec_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module htdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/htdec_ctrl.sv
// Table load, tree clearing, code walk and result staging around the tree RAM.
module htdec_ctrl #(
  parameter int TREE_ENTRIES = 1024,
  localparam int IDX_W = $clog2(TREE_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_final,
  input  logic                          cfg_valid,
  input  logic [15:0]                   cfg_data,
  input  logic [htdec_pkg::OUTQ_LVL_W-1:0] outq_level,
  output htdec_pkg::push_t              push,
  output logic                          ram_we,
  output logic [IDX_W-1:0]              ram_waddr,
  output logic [7:0]                    ram_wdata,
  output logic                          ram_re,
  output logic [IDX_W-1:0]              ram_raddr,
  input  logic [7:0]                    ram_rdata
);

  localparam logic [IDX_W:0]   TREE_LIMIT = (IDX_W+1)'(TREE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(TREE_ENTRIES - 1);

  logic             clr_active;
  logic [IDX_W-1:0] clr_addr;
  logic [15:0]      table_length;
  logic [15:0]      bytes_seen;
  logic [IDX_W-1:0] load_index;
  logic [7:0]       pending_symbol;
  logic             line_start;
  logic [IDX_W-1:0] walk_index;
  logic [7:0]       root_val;
  logic             fwd_valid;
  logic [7:0]       fwd_data;
  logic             s1_emit;
  logic [7:0]       s1_sym;
  logic             s1_ovf;
  logic             s1_flush;

  logic             accept;
  logic             table_mode;
  logic             tbl_acc;
  logic             msg_acc;
  logic             bit_one;
  logic             is_nl;
  logic [IDX_W:0]   load_child;
  logic             load_write;
  logic [7:0]       cur_val;
  logic             emit_a;
  logic [IDX_W-1:0] walk_base;
  logic [IDX_W:0]   walk_child;
  logic             walk_ovf;
  logic [1:0]       s1_n;
  logic             s1_second;
  htdec_pkg::result_t res_second;

  assign table_mode = bytes_seen < table_length;
  assign accept     = in_valid && in_ready;
  assign tbl_acc    = accept && table_mode;
  assign msg_acc    = accept && !table_mode;
  assign bit_one    = in_byte == htdec_pkg::CH_ONE;
  assign is_nl      = in_byte == htdec_pkg::CH_NEWLINE;
  assign load_child = {load_index, bit_one};
  assign load_write = tbl_acc && is_nl && (load_index != '0);

  // Current tree entry: root from its shadow, else a forwarded table write, else RAM.
  always_comb begin
    if (walk_index == IDX_ONE) begin
      cur_val = root_val;
    end else if (fwd_valid) begin
      cur_val = fwd_data;
    end else begin
      cur_val = ram_rdata;
    end
  end

  assign emit_a     = cur_val != htdec_pkg::EMPTY_SYMBOL;
  assign walk_base  = emit_a ? IDX_ONE : walk_index;
  assign walk_child = {walk_base, bit_one};
  assign walk_ovf   = walk_child >= TREE_LIMIT;

  // Fetch the child entry; it serves both the next step and a flush.
  assign ram_re    = msg_acc && !walk_ovf;
  assign ram_raddr = walk_child[IDX_W-1:0];

  assign ram_we    = clr_active || load_write;
  assign ram_waddr = clr_active ? clr_addr : load_index;
  assign ram_wdata = clr_active ? htdec_pkg::EMPTY_SYMBOL : pending_symbol;

  assign s1_second = s1_ovf || s1_flush;
  assign s1_n      = {1'b0, s1_emit} + {1'b0, s1_second};

  assign in_ready = !clr_active &&
                    ((htdec_pkg::OUTQ_LVL_W'(s1_n) + outq_level) <=
                     htdec_pkg::OUTQ_LVL_W'(2));

  always_comb begin
    res_second.sym  = s1_ovf ? htdec_pkg::EMPTY_SYMBOL : ram_rdata;
    res_second.ovf  = s1_ovf;
    res_second.last = 1'b1;
    push.cnt = s1_n;
    if (s1_emit) begin
      push.r0.sym  = s1_sym;
      push.r0.ovf  = 1'b0;
      push.r0.last = !s1_second;
      push.r1      = res_second;
    end else begin
      push.r0 = res_second;
      push.r1 = res_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active     <= 1'b1;
      clr_addr       <= '0;
      table_length   <= htdec_pkg::TABLE_LENGTH_RESET;
      bytes_seen     <= '0;
      load_index     <= IDX_ONE;
      pending_symbol <= htdec_pkg::EMPTY_SYMBOL;
      line_start     <= 1'b1;
      walk_index     <= IDX_ONE;
      root_val       <= htdec_pkg::EMPTY_SYMBOL;
      fwd_valid      <= 1'b0;
      s1_emit        <= 1'b0;
      s1_ovf         <= 1'b0;
      s1_flush       <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + IDX_ONE;
        if (clr_addr == IDX_LAST) begin
          clr_active <= 1'b0;
        end
      end
      if (cfg_valid) begin
        table_length <= cfg_data;
      end

      if (tbl_acc) begin
        bytes_seen <= bytes_seen + 16'd1;
        if (is_nl) begin
          load_index <= IDX_ONE;
          line_start <= 1'b1;
        end else if (line_start) begin
          pending_symbol <= in_byte;
          line_start     <= 1'b0;
        end else if (load_index != '0) begin
          load_index <= (load_child >= TREE_LIMIT) ? '0 : load_child[IDX_W-1:0];
        end
      end

      // Keep the root shadow and the walk forward in step with table writes.
      if (load_write && load_index == IDX_ONE) begin
        root_val <= pending_symbol;
      end
      if (load_write && load_index == walk_index) begin
        fwd_valid <= 1'b1;
        fwd_data  <= pending_symbol;
      end else if (msg_acc) begin
        fwd_valid <= 1'b0;
      end

      if (msg_acc) begin
        walk_index <= (walk_ovf || in_final) ? IDX_ONE : walk_child[IDX_W-1:0];
        s1_emit    <= emit_a;
        s1_sym     <= cur_val;
        s1_ovf     <= walk_ovf;
        s1_flush   <= in_final && !walk_ovf;
      end else begin
        s1_emit  <= 1'b0;
        s1_ovf   <= 1'b0;
        s1_flush <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/htdec_outq.sv
// Small result queue that takes up to two results a cycle and drives the output stream.
module htdec_outq (
  input  logic                             clk,
  input  logic                             rst,
  input  htdec_pkg::push_t                 push,
  output logic                             out_valid,
  input  logic                             out_ready,
  output htdec_pkg::result_t               out_res,
  output logic [htdec_pkg::OUTQ_LVL_W-1:0] level
);

  htdec_pkg::result_t                   q [htdec_pkg::OUTQ_DEPTH];
  logic [htdec_pkg::OUTQ_PTR_W-1:0]     wr_ptr;
  logic [htdec_pkg::OUTQ_PTR_W-1:0]     rd_ptr;
  logic [htdec_pkg::OUTQ_LVL_W-1:0]     count;
  logic                                 pop;
  logic [htdec_pkg::OUTQ_PTR_W-1:0]     wr_ptr1;

  assign out_valid = count != '0;
  assign out_res   = q[rd_ptr];
  assign level     = count;
  assign pop       = out_valid && out_ready;
  assign wr_ptr1   = wr_ptr + htdec_pkg::OUTQ_PTR_W'(1);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      q[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + htdec_pkg::OUTQ_PTR_W'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + htdec_pkg::OUTQ_PTR_W'(1);
      end
      count <= count + htdec_pkg::OUTQ_LVL_W'(push.cnt) -
               htdec_pkg::OUTQ_LVL_W'(pop);
    end
  end

endmodule

FILE: hw/rtl/htdec_checker.sv
// Port-level checks of the Huffman table load and decode unit, bound to the top level.
module htdec_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // Nothing leaves right after reset.
  a_no_out_after_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // The clearing pass holds input off in the cycle after reset.
  a_clear_blocks_input: assert property (@(posedge clk) $past(rst) |-> !s_axis_tready)
    else $error("input taken during tree clearing");

  // An overflow result carries an empty symbol and ends its run.
  a_ovf_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00 && m_axis_tlast)
    else $error("malformed overflow result");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind huffman_table_load_and_decode_unit htdec_checker u_htdec_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/huffman_table_load_and_decode_unit_tb.sv
// Self-checking bench for the Huffman table load and decode unit.
`timescale 1ns / 1ps

module huffman_table_load_and_decode_unit_tb;

  localparam int TREE_ENTRIES = 1024;
  localparam logic [7:0] CH_ZERO = 8'h30;       // ASCII '0'
  localparam int DRAIN_CYCLES = 8;              // idle time before a table_length write
  localparam int TAIL_CYCLES = 20;              // quiet time after the last result
  localparam int RANDOM_ITEMS = 1300;
  localparam int LONG_HOLD = 300;               // receiver back-pressure stretch
  localparam int MAX_REPORTS = 10;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // One directed step: a stream byte (with an optional typed-in result) or a register write.
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;    // stream byte in the low bits, or the table_length value
    logic        fin;
    logic        typed;    // result below is typed in; otherwise the predictor decides
    logic [1:0]  cnt;
    logic [7:0]  sym;
    logic        ovf;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } text_byte_t;

  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Empty tree, whole stream is message: walk down until the store runs out.
    '{ROW_CFG,  16'd0,                            1'b0, 1'b0, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, 16'h0000,                         1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    // Tenth bit leaves the store: overflow result, and the final mark adds no flush.
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b1, 1'b1, 2'd1, 8'h00, 1'b1},
    // Any byte other than '1' is a zero bit; flushing an empty entry gives symbol 0.
    '{ROW_BYTE, 16'h00FF,                         1'b1, 1'b1, 2'd1, 8'h00, 1'b0},
    // Widest table window; final marks inside table text are ignored.
    '{ROW_CFG,  16'hFFFF,                         1'b0, 1'b0, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, 16'h00FF,                         1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, htdec_pkg::CH_ONE},       1'b1, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, htdec_pkg::CH_NEWLINE},   1'b1, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, 16'h0041,                         1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, htdec_pkg::CH_NEWLINE},   1'b0, 1'b1, 2'd0, 8'h00, 1'b0},
    // Close the window right after the six table bytes and decode.
    '{ROW_CFG,  16'd6,                            1'b0, 1'b0, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, htdec_pkg::CH_ONE},       1'b1, 1'b1, 2'd1, 8'hFF, 1'b0},
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b0, 1'b0, 2'd0, 8'h00, 1'b0},
    '{ROW_BYTE, {8'h00, htdec_pkg::CH_ONE},       1'b0, 1'b0, 2'd0, 8'h00, 1'b0},
    // Leaf hit plus flush of the next leaf: two results from one byte.
    '{ROW_BYTE, {8'h00, CH_ZERO},                 1'b1, 1'b0, 2'd0, 8'h00, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Predictor state: an image of the code tree and the loader and walker positions.
  logic [7:0]  tree_img [TREE_ENTRIES];
  int unsigned load_pos;
  logic [7:0]  line_sym;
  logic        at_line_start;
  logic [15:0] table_bytes;
  logic [15:0] table_len;
  int unsigned walk_pos;

  htdec_pkg::result_t due_results [$];   // decoded symbols still owed by the block
  int unsigned known_codes [$];          // heap indexes of recently loaded leaves
  bit          root_set;          // a codeless line has put a symbol at the root
  int          mismatch_count;
  int          items_sent;
  int          burst_left;
  bit          steady;            // sender runs with no gaps in this phase
  int          hold_left;         // receiver back-pressure, counted down per cycle

  huffman_table_load_and_decode_unit #(
    .TREE_ENTRIES(TREE_ENTRIES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predictor by one accepted byte; return the results it causes.
  function automatic htdec_pkg::push_t decode_byte(input logic [7:0] b, input logic fin);
    htdec_pkg::push_t   p;
    htdec_pkg::result_t rr [2];
    int                 n;
    int unsigned        bit_v;
    int unsigned        nxt;
    logic               ran_out;
    p = '0;
    rr[0] = '0;
    rr[1] = '0;
    n = 0;
    ran_out = 1'b0;
    bit_v = (b == htdec_pkg::CH_ONE) ? 1 : 0;
    if (table_bytes < table_len) begin
      table_bytes = table_bytes + 16'd1;
      if (b == htdec_pkg::CH_NEWLINE) begin
        // An invalidated line (load_pos 0) stores nothing.
        if (load_pos != 0) tree_img[load_pos] = line_sym;
        load_pos = 1;
        at_line_start = 1'b1;
      end else if (at_line_start) begin
        line_sym = b;
        at_line_start = 1'b0;
      end else if (load_pos != 0) begin
        nxt = 2 * load_pos + bit_v;
        load_pos = (nxt < TREE_ENTRIES) ? nxt : 0;
      end
      return p;
    end
    // Emit a leaf reached by the previous bit, then restart at the root.
    if (tree_img[walk_pos] != htdec_pkg::EMPTY_SYMBOL) begin
      rr[n] = '{sym: tree_img[walk_pos], ovf: 1'b0, last: 1'b0};
      n++;
      walk_pos = 1;
    end
    nxt = 2 * walk_pos + bit_v;
    if (nxt >= TREE_ENTRIES) begin
      rr[n] = '{sym: 8'h00, ovf: 1'b1, last: 1'b0};
      n++;
      walk_pos = 1;
      ran_out = 1'b1;
    end else begin
      walk_pos = nxt;
    end
    if (fin && !ran_out) begin
      rr[n] = '{sym: tree_img[walk_pos], ovf: 1'b0, last: 1'b0};
      n++;
      walk_pos = 1;
    end
    if (n > 0) rr[n-1].last = 1'b1;
    p.cnt = 2'(n);
    p.r0 = rr[0];
    p.r1 = rr[1];
    return p;
  endfunction

  // A zero bit: mostly ASCII '0', sometimes any other byte that is neither '1' nor newline.
  function automatic logic [7:0] zero_byte();
    logic [7:0] b;
    b = CH_ZERO;
    if ($urandom_range(0, 7) == 0) begin
      b = 8'($urandom);
      if (b == htdec_pkg::CH_ONE || b == htdec_pkg::CH_NEWLINE) b = CH_ZERO;
    end
    return b;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
  endtask

  // Offer one byte, hold it until the transaction, then record what it should decode to.
  task automatic push_byte(input logic [7:0] b, input logic fin, input bit typed = 1'b0,
                           input logic [1:0] t_cnt = 2'd0, input logic [7:0] t_sym = 8'h00,
                           input logic t_ovf = 1'b0);
    htdec_pkg::push_t got;
    int               gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    got = decode_byte(b, fin);
    if (typed) begin
      if (t_cnt == 2'd1) due_results.push_back('{sym: t_sym, ovf: t_ovf, last: 1'b1});
    end else begin
      if (got.cnt > 0) due_results.push_back(got.r0);
      if (got.cnt > 1) due_results.push_back(got.r1);
    end
  endtask

  // Drop valid and hold the sender until every owed result has come out.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Write table_length only once the block has gone quiet.
  task automatic set_table_length(input logic [15:0] value);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    table_len = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One phase: load up to six code lines, then decode a message built mostly from loaded codes.
  task automatic run_phase(input int phase_no);
    text_byte_t  text_q [$];
    int          mode;
    int          nlines;
    int          len;
    int          cut;
    int          nwords;
    int          n;
    logic [7:0]  sym;
    logic [7:0]  b;
    logic        fin;
    int unsigned idx;
    int unsigned code;
    text_q = {};
    steady = ($urandom_range(0, 3) == 0);
    mode = $urandom_range(0, 9);
    if (mode != 0) begin
      nlines = $urandom_range(1, 6);
      for (int l = 0; l < nlines; l++) begin
        sym = ($urandom_range(0, 7) == 0) ? htdec_pkg::EMPTY_SYMBOL : 8'($urandom);
        if (sym == htdec_pkg::CH_NEWLINE) sym = 8'h0b;
        case ($urandom_range(0, 19))
          0:             len = 0;
          1, 2:          len = $urandom_range(10, 11);   // runs past the store
          3, 4, 5, 6, 7: len = $urandom_range(6, 9);
          default:       len = $urandom_range(1, 5);
        endcase
        // Clear a symbol left at the root by a codeless line in an earlier phase.
        if (root_set && l == 0) begin
          len = 0;
          sym = htdec_pkg::EMPTY_SYMBOL;
        end
        if (len == 0) root_set = (sym != htdec_pkg::EMPTY_SYMBOL);
        text_q.push_back('{b: sym, fin: 1'($urandom)});
        idx = 1;
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 1) == 1) begin
            text_q.push_back('{b: htdec_pkg::CH_ONE, fin: 1'($urandom)});
            idx = 2 * idx + 1;
          end else begin
            text_q.push_back('{b: zero_byte(), fin: 1'($urandom)});
            idx = 2 * idx;
          end
        end
        text_q.push_back('{b: htdec_pkg::CH_NEWLINE, fin: 1'($urandom)});
        if (len >= 1 && len <= 9 && sym != htdec_pkg::EMPTY_SYMBOL) begin
          known_codes.push_back(idx);
          if (known_codes.size() > 24) void'(known_codes.pop_front());
        end
      end
    end

    if (mode == 0) begin
      // No table text at all: the window closes at zero.
      set_table_length(16'd0);
    end else if (mode == 1) begin
      // Open the window as wide as it goes, then shut it behind the text.
      set_table_length(16'hFFFF);
      foreach (text_q[i]) push_byte(text_q[i].b, text_q[i].fin);
      set_table_length(table_bytes);
    end else begin
      // Sometimes cut the window short so the tail of the text decodes as message.
      cut = (mode == 2) ? $urandom_range(1, 3) : 0;
      if (cut > text_q.size()) cut = 0;
      set_table_length(16'(int'(table_bytes) + text_q.size() - cut));
      foreach (text_q[i]) push_byte(text_q[i].b, text_q[i].fin);
    end

    // Back-pressure the output for a long stretch while the sender keeps going.
    if (phase_no == 2) hold_left = LONG_HOLD;

    nwords = $urandom_range(5, 40);
    for (int w = 0; w < nwords; w++) begin
      if ($urandom_range(0, 29) == 0) drain();
      if (known_codes.size() > 0 && $urandom_range(0, 6) != 0) begin
        code = known_codes[$urandom_range(0, known_codes.size() - 1)];
        len = 0;
        while ((code >> (len + 1)) != 0) len++;
        for (int k = len - 1; k >= 0; k--) begin
          b = code[k] ? htdec_pkg::CH_ONE : zero_byte();
          fin = (k == 0) && ($urandom_range(0, 3) == 0);
          push_byte(b, fin);
        end
      end else if ($urandom_range(0, 2) == 0) begin
        // Long run of one bit: deep descent, likely past the store.
        b = $urandom_range(0, 1) ? htdec_pkg::CH_ONE : CH_ZERO;
        n = $urandom_range(10, 13);
        for (int k = 0; k < n; k++) push_byte(b, ($urandom_range(0, 7) == 0));
      end else begin
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          b = $urandom_range(0, 1) ? htdec_pkg::CH_ONE : 8'($urandom);
          push_byte(b, ($urandom_range(0, 5) == 0));
        end
      end
    end
  endtask

  // Receiver: a long hold when asked, otherwise a 16-bit ready mask redrawn on pat_pos wrap.
  initial begin
    logic [15:0] ready_mask;
    logic [6:0]  pat_pos;
    m_axis_tready = 1'b0;
    ready_mask = 16'hFFFF;
    pat_pos = '0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (pat_pos == 0) begin
          case ($urandom_range(0, 3))
            0:       ready_mask = 16'hFFFF;
            1:       ready_mask = 16'($urandom);
            2:       ready_mask = 16'($urandom) & 16'($urandom);
            default: ready_mask = 16'($urandom) | 16'($urandom);
          endcase
        end
        m_axis_tready <= ready_mask[pat_pos[3:0]];
        pat_pos = pat_pos + 7'd1;
      end
    end
  end

  // Check every output transaction against the oldest owed result.
  always @(posedge clk) begin
    htdec_pkg::result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result sym=%02h ovf=%0b last=%0b",
                                m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        exp_r = due_results.pop_front();
        if (m_axis_tdata !== exp_r.sym || m_axis_tuser !== exp_r.ovf ||
            m_axis_tlast !== exp_r.last) begin
          note_mismatch($sformatf({"expected sym=%02h ovf=%0b last=%0b, ",
                                   "got sym=%02h ovf=%0b last=%0b"},
                                  exp_r.sym, exp_r.ovf, exp_r.last,
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int phase_no;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 16'h0000;
    foreach (tree_img[i]) tree_img[i] = htdec_pkg::EMPTY_SYMBOL;
    load_pos = 1;
    line_sym = 8'h00;
    at_line_start = 1'b1;
    table_bytes = 16'd0;
    table_len = htdec_pkg::TABLE_LENGTH_RESET;
    walk_pos = 1;
    root_set = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    burst_left = 0;
    steady = 1'b0;
    hold_left = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed steps; the handshake waits out the tree clear after reset.
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        set_table_length(DIRECTED[r].value);
      end else begin
        push_byte(DIRECTED[r].value[7:0], DIRECTED[r].fin, DIRECTED[r].typed,
                  DIRECTED[r].cnt, DIRECTED[r].sym, DIRECTED[r].ovf);
      end
    end

    phase_no = 0;
    while (items_sent < RANDOM_ITEMS + N_DIRECTED) begin
      run_phase(phase_no);
      phase_no++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0) note_mismatch("results still owed at end of run");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
